// ----- rtl/core/nnls_pkg.sv -----
// Shared types and constants of the nearest neighbor linear scan block.
// No dependencies; every module of the block imports this package.
package nnls_pkg;

    // Default sizes of the point store
    localparam int POINTS_DEF = 1024;
    localparam int DIMENSIONS_DEF = 4;

    // Fixed field widths
    localparam int COORD_W = 16;
    localparam int NUM_COORDS = 4;
    localparam int SLOT_W = 10;
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int DIST_W = 34;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int REG_IDX_W = 1;
    localparam logic [REG_IDX_W-1:0] REG_POINT_COUNT = 1'b0;

    // Request function codes
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    typedef enum logic [1:0] {
        KIND_LOAD,
        KIND_QUERY,
        KIND_DROP
    } t_kind;

    typedef logic [NUM_COORDS-1:0][COORD_W-1:0] t_coords;

    typedef struct packed {
        t_kind kind;
        logic [SLOT_W-1:0] slot;
        t_coords coords;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_RESULT
    } t_back_state;

endpackage

// ----- rtl/core/nnls_front.sv -----
// Front of the nearest neighbor scan: registers each request and classifies it.
// Depends on nnls_pkg.
module nnls_front #(
    parameter int POINTS = nnls_pkg::POINTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic [nnls_pkg::SLOT_W-1:0]  i_slot,
    input  logic [nnls_pkg::COORD_W-1:0] i_coord_a,
    input  logic [nnls_pkg::COORD_W-1:0] i_coord_b,
    input  logic [nnls_pkg::COORD_W-1:0] i_coord_c,
    input  logic [nnls_pkg::COORD_W-1:0] i_coord_d,
    output logic                         o_push,
    output nnls_pkg::t_cmd               o_cmd,
    input  logic                         i_full
);
    import nnls_pkg::*;

    localparam int PCW = $clog2(POINTS + 1);
    localparam int SCW = (SLOT_W > PCW) ? SLOT_W : PCW;

    logic  r_vld;
    t_cmd  r_cmd;
    t_kind w_kind;
    logic  w_leave;
    logic  w_accept;

    // Drop loads aimed past the end of the store
    always_comb begin
        if (i_func == FUNC_QUERY) begin
            w_kind = KIND_QUERY;
        end else if (SCW'(i_slot) < SCW'(POINTS)) begin
            w_kind = KIND_LOAD;
        end else begin
            w_kind = KIND_DROP;
        end
    end

    assign w_leave  = r_vld && ((r_cmd.kind == KIND_DROP) || !i_full);
    assign o_push   = r_vld && (r_cmd.kind != KIND_DROP) && !i_full;
    assign o_ready  = !r_vld || w_leave;
    assign w_accept = i_valid && o_ready;
    assign o_cmd    = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_accept) begin
            r_vld <= 1'b1;
        end else if (w_leave) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd.kind   <= w_kind;
            r_cmd.slot   <= i_slot;
            r_cmd.coords <= {i_coord_d, i_coord_c, i_coord_b, i_coord_a};
        end
    end

endmodule

// ----- rtl/core/nnls_queue.sv -----
// Short command queue that decouples the request front from the scan back.
// Depends on nnls_pkg.
module nnls_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  nnls_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_valid,
    output nnls_pkg::t_cmd o_cmd,
    input  logic           i_pop
);
    import nnls_pkg::*;

    t_cmd              r_slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_do_push;
    logic              w_do_pop;

    assign o_full    = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_cmd     = r_slots[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/nnls_back.sv -----
// Back of the nearest neighbor scan: point store, distance pipeline, best tracking.
// Depends on nnls_pkg; fed by nnls_queue.
module nnls_back #(
    parameter int POINTS     = nnls_pkg::POINTS_DEF,
    parameter int DIMENSIONS = nnls_pkg::DIMENSIONS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [nnls_pkg::COUNT_W-1:0] i_point_count,
    input  logic                         i_cmd_valid,
    input  nnls_pkg::t_cmd               i_cmd,
    output logic                         o_cmd_pop,
    output logic                         o_valid,
    output logic [nnls_pkg::INDEX_W-1:0] o_nearest_index,
    input  logic                         i_ready
);
    import nnls_pkg::*;

    localparam int AW   = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int CW   = $clog2(POINTS + 1);
    localparam int CMPW = (COUNT_W > CW) ? COUNT_W : CW;
    localparam int PW   = DIMENSIONS * COORD_W;
    localparam int SQW  = 2 * COORD_W;

    t_back_state r_state;
    t_back_state n_state;

    logic [CW-1:0]      r_left;
    logic [CW-1:0]      w_left_m1;
    logic [CW-1:0]      w_eff_count;
    t_coords            r_query;

    logic [PW-1:0]      r_mem [POINTS];
    logic [PW-1:0]      r_rd_data;
    logic [PW-1:0]      w_wr_data;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic               w_rd_en;
    logic               w_start;
    logic               w_result_load;

    logic               r_p1_vld;
    logic               r_p2_vld;
    logic               r_p3_vld;
    logic [AW-1:0]      r_p1_idx;
    logic [AW-1:0]      r_p2_idx;
    logic [AW-1:0]      r_p3_idx;
    logic [COORD_W-1:0] w_diff [DIMENSIONS];
    logic [SQW-1:0]     r_sq [DIMENSIONS];
    logic [DIST_W-1:0]  w_sum;
    logic [DIST_W-1:0]  r_dist;
    logic [DIST_W-1:0]  r_best_dist;
    logic [AW-1:0]      r_best_idx;
    logic               r_have;

    logic               r_out_vld;
    logic [INDEX_W-1:0] r_out_idx;

    // Clamp the configured count to the store depth
    always_comb begin
        if (CMPW'(i_point_count) > CMPW'(POINTS)) begin
            w_eff_count = CW'(POINTS);
        end else begin
            w_eff_count = CW'(i_point_count);
        end
    end

    assign w_left_m1 = r_left - CW'(1);
    assign w_rd_addr = w_left_m1[AW-1:0];

    always_comb begin
        for (int k = 0; k < DIMENSIONS; k++) begin
            w_wr_data[k*COORD_W +: COORD_W] = i_cmd.coords[k];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid && (i_cmd.kind == KIND_QUERY)) begin
                    n_state = BK_SCAN;
                end
            end
            BK_SCAN: begin
                if (r_left == '0) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                if (!(r_p1_vld || r_p2_vld || r_p3_vld)) begin
                    n_state = BK_RESULT;
                end
            end
            BK_RESULT: begin
                if (!r_out_vld || i_ready) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_cmd_pop     = 1'b0;
        w_wr_en       = 1'b0;
        w_start       = 1'b0;
        w_rd_en       = 1'b0;
        w_result_load = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                o_cmd_pop = i_cmd_valid;
                w_wr_en   = i_cmd_valid && (i_cmd.kind == KIND_LOAD);
                w_start   = i_cmd_valid && (i_cmd.kind == KIND_QUERY);
            end
            BK_SCAN: begin
                w_rd_en = (r_left != '0);
            end
            BK_DRAIN: begin
                w_rd_en = 1'b0;
            end
            BK_RESULT: begin
                w_result_load = !r_out_vld || i_ready;
            end
            default: w_rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_p1_vld <= 1'b0;
            r_p2_vld <= 1'b0;
            r_p3_vld <= 1'b0;
            r_have   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= w_rd_en;
            r_p2_vld <= r_p1_vld;
            r_p3_vld <= r_p2_vld;
            if (w_start) begin
                r_have <= 1'b0;
            end else if (r_p3_vld) begin
                r_have <= 1'b1;
            end
            if (w_result_load) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Scan counter and query latch
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_left  <= w_eff_count;
            r_query <= i_cmd.coords;
        end else if (w_rd_en) begin
            r_left <= w_left_m1;
        end
    end

    // Point store
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[AW'(i_cmd.slot)] <= w_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Per-dimension absolute difference, squared in the next register
    always_comb begin
        for (int k = 0; k < DIMENSIONS; k++) begin
            if (r_rd_data[k*COORD_W +: COORD_W] >= r_query[k]) begin
                w_diff[k] = r_rd_data[k*COORD_W +: COORD_W] - r_query[k];
            end else begin
                w_diff[k] = r_query[k] - r_rd_data[k*COORD_W +: COORD_W];
            end
        end
    end

    always_comb begin
        w_sum = '0;
        for (int k = 0; k < DIMENSIONS; k++) begin
            w_sum = w_sum + DIST_W'(r_sq[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_idx <= w_rd_addr;
        r_p2_idx <= r_p1_idx;
        r_p3_idx <= r_p2_idx;
        r_dist   <= w_sum;
        for (int k = 0; k < DIMENSIONS; k++) begin
            r_sq[k] <= SQW'(w_diff[k]) * SQW'(w_diff[k]);
        end
    end

    // Keep the best so far; a tie keeps the earlier, higher index
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_best_idx <= '0;
        end else if (r_p3_vld && (!r_have || (r_dist < r_best_dist))) begin
            r_best_idx  <= r_p3_idx;
            r_best_dist <= r_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_result_load) begin
            r_out_idx <= INDEX_W'(r_best_idx);
        end
    end

    assign o_valid         = r_out_vld;
    assign o_nearest_index = r_out_idx;

endmodule

// ----- rtl/core/nearest_neighbor_linear_scan.sv -----
// Nearest neighbor linear scan over a store of reference points.
//
// Requests enter on a valid/ready channel. func 0 loads the coordinates into
// store entry slot and gives no result; a load past the end of the store is
// dropped. func 1 is a query: the first point_count entries (clamped to
// POINTS) are read from the highest index down, one entry per cycle through
// the single read port of the point store, and the index of the entry with
// the smallest squared distance comes out; equal distances keep the higher
// index, and an empty set answers 0.
// A query's result waits on the scan and the distance pipeline. A new
// query starts once the previous result is in the output register; loads go
// one per cycle while no query is in progress. point_count is written over the
// APB port at byte address 0; the user must write it only while idle, and the
// block itself does not enforce it. Reset clears the control state and
// point_count; store contents are undefined until loaded, so no entry may be
// queried before it is written. A result waits in the output register while
// the receiver stalls; the front register and the two-entry command queue keep
// taking requests meanwhile, and the input backs up once they are full.
// Depends on nnls_pkg, nnls_front, nnls_queue and nnls_back.
module nearest_neighbor_linear_scan #(
    parameter int POINTS     = nnls_pkg::POINTS_DEF,
    parameter int DIMENSIONS = nnls_pkg::DIMENSIONS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic [nnls_pkg::SLOT_W-1:0]  i_slot,
    input  logic [nnls_pkg::COORD_W-1:0] i_coord_a,
    input  logic [nnls_pkg::COORD_W-1:0] i_coord_b,
    input  logic [nnls_pkg::COORD_W-1:0] i_coord_c,
    input  logic [nnls_pkg::COORD_W-1:0] i_coord_d,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [nnls_pkg::INDEX_W-1:0] o_nearest_index,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [nnls_pkg::PADDR_W-1:0] paddr,
    input  logic [nnls_pkg::PDATA_W-1:0] pwdata,
    output logic [nnls_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import nnls_pkg::*;

    logic [COUNT_W-1:0]   r_point_count;
    logic [REG_IDX_W-1:0] w_reg_idx;
    logic                 w_front_push;
    t_cmd                 w_front_cmd;
    logic                 w_q_full;
    logic                 w_q_valid;
    t_cmd                 w_q_cmd;
    logic                 w_q_pop;

    assign pready    = 1'b1;
    assign w_reg_idx = paddr[PADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
        end else if (psel && penable && pwrite && pready && (w_reg_idx == REG_POINT_COUNT)) begin
            r_point_count <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        if (w_reg_idx == REG_POINT_COUNT) begin
            prdata = PDATA_W'(r_point_count);
        end else begin
            prdata = '0;
        end
    end

    nnls_front #(
        .POINTS (POINTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_func    (i_func),
        .i_slot    (i_slot),
        .i_coord_a (i_coord_a),
        .i_coord_b (i_coord_b),
        .i_coord_c (i_coord_c),
        .i_coord_d (i_coord_d),
        .o_push    (w_front_push),
        .o_cmd     (w_front_cmd),
        .i_full    (w_q_full)
    );

    nnls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    nnls_back #(
        .POINTS     (POINTS),
        .DIMENSIONS (DIMENSIONS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_point_count   (r_point_count),
        .i_cmd_valid     (w_q_valid),
        .i_cmd           (w_q_cmd),
        .o_cmd_pop       (w_q_pop),
        .o_valid         (o_valid),
        .o_nearest_index (o_nearest_index),
        .i_ready         (i_ready)
    );

endmodule

// ----- rtl/core/nnls_checker.sv -----
// Port-level checks for nearest_neighbor_linear_scan, attached by bind.
// Depends on nnls_pkg and the top-level port list.
module nnls_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_ready,
    input logic [nnls_pkg::INDEX_W-1:0] o_nearest_index,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [nnls_pkg::PADDR_W-1:0] paddr,
    input logic [nnls_pkg::PDATA_W-1:0] pwdata,
    input logic [nnls_pkg::PDATA_W-1:0] prdata
);
    import nnls_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_nearest_index))
        else $error("result changed while stalled");

    // No result right after reset
    a_reset_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid straight out of reset");

    // Count register reads back what was written
    a_count_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_POINT_COUNT)
        |=> (paddr[PADDR_W-1:2] != REG_POINT_COUNT)
            || (prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0])))
        else $error("point_count readback mismatch");

    // Unused register bits read as zero
    a_upper_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        prdata[PDATA_W-1:COUNT_W] == '0)
        else $error("nonzero upper register bits");

endmodule

bind nearest_neighbor_linear_scan nnls_checker u_nnls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_nearest_index (o_nearest_index),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata)
);
